// ===== design/sfhc_pkg.sv =====
package sfhc_pkg;

	localparam int TIME_WIDTH = 32;
	localparam int PERIOD_W   = 10;
	localparam int BRIGHT_W   = 12;
	localparam int DIV_STEPS  = PERIOD_W;
	localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
	localparam int RESP_LEN   = 14;
	localparam int RESP_IDX_W = $clog2(RESP_LEN);
	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);
	localparam int S_TDATA_W  = 64;
	localparam int M_TDATA_W  = 24;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam int CTRL_ENABLE_BIT = 0;
	localparam int CTRL_STOP_BIT   = 1;

	localparam logic [7:0] START_BYTE  = 8'h1C;
	localparam logic [7:0] ID_BYTE     = 8'h68;
	localparam logic [7:0] END_BYTE    = 8'h0D;
	localparam logic [7:0] CODE_OFFSET = 8'h20;
	localparam logic [7:0] PAD_BYTE    = 8'h00;

	localparam logic [PERIOD_W-1:0] DIVIDEND       = PERIOD_W'(1000);
	localparam logic [PERIOD_W-1:0] DEFAULT_PERIOD = PERIOD_W'(1000);
	localparam logic [15:0]         TIMEOUT_RESET  = 16'd2000;
	localparam logic [7:0]          FW_RESET       = 8'h10;
	localparam logic [BRIGHT_W-1:0] BRIGHT_RESET   = BRIGHT_W'(30);

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FW      = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		IT_TICK,
		IT_BAD,
		IT_PKT
	} item_kind_t;

	typedef struct packed {
		item_kind_t kind;
		logic [7:0] freq_code;
		logic [7:0] int_code;
		logic [7:0] flash_code;
		logic       enable;
		logic       stop;
		logic       trigger;
	} item_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_EMIT
	} back_state_t;

	typedef struct packed {
		logic [15:0] timeout_ms;
		logic [7:0]  fw_version;
	} cfg_t;

	typedef struct packed {
		logic                kind;
		logic [7:0]          resp_byte;
		logic                last;
		logic                pwm;
		logic [BRIGHT_W-1:0] bright;
		logic                run;
		logic                err;
	} result_t;

	function automatic logic [BRIGHT_W-1:0] brightness(input logic [7:0] code);
		return BRIGHT_W'({code, 3'b000}) + BRIGHT_W'({code, 1'b0});
	endfunction

endpackage

// ===== design/sfhc_front.sv =====
module sfhc_front (
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// start, id, freq, intensity, flash, control, end bytes, trigger_level, zero pad
	input  logic [sfhc_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// command
	input  logic                           s_axis_tuser,
	input  logic                           q_full,
	output logic                           push,
	output sfhc_pkg::item_t                item
);
	import sfhc_pkg::*;

	logic [7:0] ctrl;
	logic       frame_ok;

	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && !q_full;
	assign ctrl          = s_axis_tdata[47:40];
	assign frame_ok      = (s_axis_tdata[7:0] == START_BYTE) && (s_axis_tdata[15:8] == ID_BYTE)
		&& (s_axis_tdata[55:48] == END_BYTE);

	always_comb begin
		if (!s_axis_tuser) begin
			item.kind = IT_TICK;
		end else if (frame_ok) begin
			item.kind = IT_PKT;
		end else begin
			item.kind = IT_BAD;
		end
		item.freq_code  = s_axis_tdata[23:16] - CODE_OFFSET;
		item.int_code   = s_axis_tdata[31:24] - CODE_OFFSET;
		item.flash_code = s_axis_tdata[39:32] - CODE_OFFSET;
		item.enable     = ctrl[CTRL_ENABLE_BIT];
		item.stop       = ctrl[CTRL_STOP_BIT];
		item.trigger    = s_axis_tdata[56];
	end

endmodule

// ===== design/sfhc_queue.sv =====
module sfhc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sfhc_pkg::item_t item_in,
	input  logic            pop,
	output logic            full,
	output logic            valid,
	output sfhc_pkg::item_t item_out
);
	import sfhc_pkg::*;

	item_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wptr_q;
	logic [Q_PTR_W-1:0] rptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign full     = (count_q == Q_CNT_W'(Q_DEPTH));
	assign valid    = (count_q != '0);
	assign item_out = mem_q[rptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= item_in;
		end
	end

endmodule

// ===== design/sfhc_div.sv =====
module sfhc_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [7:0]                    divisor,
	output logic                          done,
	output logic [sfhc_pkg::PERIOD_W-1:0] quotient
);
	import sfhc_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [PERIOD_W-1:0]  dvd_q;
	logic [7:0]           rem_q;
	logic [7:0]           div_q;
	logic [8:0]           r_sh;
	logic [8:0]           r_diff;
	logic                 fits;

	assign r_sh     = {rem_q, dvd_q[PERIOD_W-1]};
	assign r_diff   = r_sh - {1'b0, div_q};
	assign fits     = (r_sh >= {1'b0, div_q});
	assign done     = done_q;
	assign quotient = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= DIVIDEND;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[PERIOD_W-2:0], fits};
			rem_q <= fits ? r_diff[7:0] : r_sh[7:0];
		end
	end

endmodule

// ===== design/sfhc_back.sv =====
module sfhc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sfhc_pkg::cfg_t    cfg,
	input  logic              q_valid,
	input  sfhc_pkg::item_t   q_item,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output sfhc_pkg::result_t out_res
);
	import sfhc_pkg::*;

	back_state_t           state_q;
	back_state_t           state_d;
	logic [TIME_WIDTH-1:0] now_q;
	logic [TIME_WIDTH-1:0] hb_q;
	logic [TIME_WIDTH-1:0] toggle_q;
	logic [PERIOD_W-1:0]   period_q;
	logic [7:0]            freq_q;
	logic [7:0]            int_q;
	logic [7:0]            flash_q;
	logic [BRIGHT_W-1:0]   bright_q;
	logic                  run_q;
	logic                  phase_q;
	logic                  pwm_q;
	logic                  terr_q;
	logic                  trig_q;
	logic [RESP_IDX_W-1:0] idx_q;
	logic                  out_valid_q;
	result_t               out_q;

	logic                  out_free;
	logic                  load;
	logic                  emit;
	logic                  div_start;
	logic                  div_go;
	logic                  div_done;
	logic [PERIOD_W-1:0]   div_quot;
	logic [TIME_WIDTH-1:0] t_now;
	logic [TIME_WIDTH-1:0] hb_diff;
	logic [TIME_WIDTH-1:0] since;
	logic [TIME_WIDTH-1:0] t_toggle;
	logic                  t_run;
	logic                  t_pwm;
	logic                  t_phase;
	logic                  t_terr;
	logic [7:0]            resp [RESP_LEN];

	sfhc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (q_item.freq_code),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign div_go    = !q_item.stop && q_item.enable && (q_item.freq_code != '0);

	always_comb begin
		t_now    = now_q + TIME_WIDTH'(1);
		hb_diff  = t_now - hb_q;
		t_run    = run_q;
		t_pwm    = pwm_q;
		t_phase  = phase_q;
		t_toggle = toggle_q;
		t_terr   = terr_q;
		if ((hb_diff > TIME_WIDTH'(cfg.timeout_ms)) && !terr_q) begin
			t_run  = 1'b0;
			t_pwm  = 1'b0;
			t_terr = 1'b1;
		end
		since = t_now - toggle_q;
		if (t_run) begin
			if (phase_q) begin
				if (since >= TIME_WIDTH'(flash_q)) begin
					t_pwm   = 1'b0;
					t_phase = 1'b0;
				end
			end else if (since >= TIME_WIDTH'(period_q)) begin
				t_pwm    = 1'b1;
				t_phase  = 1'b1;
				t_toggle = t_now;
			end
		end
	end

	always_comb begin
		resp[0]  = START_BYTE;
		resp[1]  = ID_BYTE;
		resp[2]  = freq_q + CODE_OFFSET;
		resp[3]  = CODE_OFFSET;
		resp[4]  = int_q + CODE_OFFSET;
		resp[5]  = flash_q + CODE_OFFSET;
		resp[6]  = {4'b0000, terr_q, 1'b0, !run_q, run_q};
		resp[7]  = {7'b0000000, trig_q};
		resp[8]  = {7'b0000000, terr_q};
		resp[9]  = cfg.fw_version;
		resp[10] = PAD_BYTE;
		resp[11] = PAD_BYTE;
		resp[12] = PAD_BYTE;
		resp[13] = END_BYTE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		load      = 1'b0;
		emit      = 1'b0;
		div_start = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (q_valid && out_free) begin
					pop = 1'b1;
					if (q_item.kind == IT_PKT) begin
						if (div_go) begin
							div_start = 1'b1;
							state_d   = BK_DIV;
						end else begin
							state_d = BK_EMIT;
						end
					end else begin
						load = 1'b1;
					end
				end
			end
			BK_DIV: begin
				if (div_done) begin
					state_d = BK_EMIT;
				end
			end
			BK_EMIT: begin
				if (out_free) begin
					emit = 1'b1;
					if (idx_q == RESP_IDX_W'(RESP_LEN - 1)) begin
						state_d = BK_IDLE;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			hb_q        <= '0;
			toggle_q    <= '0;
			period_q    <= '0;
			freq_q      <= '0;
			int_q       <= '0;
			flash_q     <= '0;
			bright_q    <= BRIGHT_RESET;
			run_q       <= 1'b0;
			phase_q     <= 1'b0;
			pwm_q       <= 1'b0;
			terr_q      <= 1'b0;
			trig_q      <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && (q_item.kind == IT_TICK)) begin
				now_q    <= t_now;
				toggle_q <= t_toggle;
				run_q    <= t_run;
				pwm_q    <= t_pwm;
				phase_q  <= t_phase;
				terr_q   <= t_terr;
			end else if (pop && (q_item.kind == IT_PKT)) begin
				hb_q   <= now_q;
				terr_q <= 1'b0;
				trig_q <= q_item.trigger;
				idx_q  <= '0;
				if (q_item.stop) begin
					run_q <= 1'b0;
					pwm_q <= 1'b0;
				end else if (q_item.enable) begin
					freq_q  <= q_item.freq_code;
					flash_q <= q_item.flash_code;
					int_q   <= q_item.int_code;
					if (!run_q || (q_item.int_code != int_q)) begin
						bright_q <= brightness(q_item.int_code);
					end
					if (q_item.freq_code == '0) begin
						period_q <= DEFAULT_PERIOD;
					end
					if (!run_q) begin
						run_q    <= 1'b1;
						toggle_q <= now_q;
						pwm_q    <= 1'b1;
						phase_q  <= 1'b1;
					end
				end else begin
					run_q <= 1'b0;
					pwm_q <= 1'b0;
				end
			end
			if (div_done) begin
				period_q <= div_quot;
			end
			if (emit) begin
				idx_q <= (idx_q == RESP_IDX_W'(RESP_LEN - 1)) ? '0 : idx_q + 1'b1;
			end
			if (load || emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.kind      <= 1'b0;
			out_q.resp_byte <= PAD_BYTE;
			out_q.last      <= 1'b1;
			out_q.bright    <= bright_q;
			if (q_item.kind == IT_TICK) begin
				out_q.pwm <= t_pwm;
				out_q.run <= t_run;
				out_q.err <= t_terr;
			end else begin
				out_q.pwm <= pwm_q;
				out_q.run <= run_q;
				out_q.err <= terr_q;
			end
		end else if (emit) begin
			out_q.kind      <= 1'b1;
			out_q.resp_byte <= resp[idx_q];
			out_q.last      <= (idx_q == RESP_IDX_W'(RESP_LEN - 1));
			out_q.pwm       <= pwm_q;
			out_q.bright    <= bright_q;
			out_q.run       <= run_q;
			out_q.err       <= terr_q;
		end
	end

endmodule

// ===== design/strobe_flash_heartbeat_controller.sv =====
// Strobe flash controller with host heartbeat supervision.
// The s_axis channel takes one item per transaction: a one millisecond tick
// (tuser low) or a received host packet (tuser high). The m_axis channel
// returns the results: a tick or a malformed packet gives one status result
// with tlast set; a valid packet gives the 14 bytes of the status response,
// one per transaction, with tlast on the last byte. Every result also carries
// the LED drive enable, brightness, run flag and error code after the item.
// The cfg channel writes timeout_ms (index 0) and firmware_version (index 1)
// and is always ready; write it only while the block is idle.
// Items pass through a two-entry queue between the classifier and the
// executing back end. A tick or a malformed packet is handled straight from
// the queue, and its result goes out through the output register. A valid
// packet leaves the queue and then sends the 14 response bytes, after first
// running the serial 1000 / freq divider when it enables the strobe with a
// nonzero frequency; the packet holds the back end until its last byte.
// Reset stops the strobe, clears the clock, timers and codes, sets the
// brightness to 30 and restores the register defaults. When m_axis stalls,
// the output register holds its result, the back end waits, and s_axis
// drops tready once the queue is full.
module strobe_flash_heartbeat_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// start, id, freq, intensity, flash, control, end bytes, trigger_level, zero pad
	input  logic [sfhc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// command
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// response_byte, pwm_on, brightness_pct, running, timeout_flag, zero pad
	output logic [sfhc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
	// kind
	output logic                            m_axis_tuser,
	output logic                            m_axis_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [sfhc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfhc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sfhc_pkg::*;

	cfg_t    cfg_q;
	logic    q_full;
	logic    q_valid;
	logic    push;
	logic    pop;
	item_t   in_item;
	item_t   q_item;
	result_t res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ms <= TIMEOUT_RESET;
			cfg_q.fw_version <= FW_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TIMEOUT: cfg_q.timeout_ms <= cfg_data;
				REG_FW:      cfg_q.fw_version <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	sfhc_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_full        (q_full),
		.push          (push),
		.item          (in_item)
	);

	sfhc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item_in  (in_item),
		.pop      (pop),
		.full     (q_full),
		.valid    (q_valid),
		.item_out (q_item)
	);

	sfhc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {1'b0, res.err, res.run, res.bright, res.pwm, res.resp_byte};
	assign m_axis_tuser = res.kind;
	assign m_axis_tlast = res.last;

`ifndef SYNTHESIS
	a_status_single : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
		else $error("status-only result without tlast");

	a_pwm_needs_run : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tdata[21])
		else $error("LED drive enabled while strobe stopped");

	a_error_stops : assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[22] |-> !m_axis_tdata[21])
		else $error("strobe running during heartbeat timeout");
`endif

endmodule
